// ===== src/hsfs_pkg.sv =====
// Shared constants, types and helper functions for the FTCS heat stencil step unit.
package hsfs_pkg;

    localparam int VALUE_BITS = 24;
    localparam int MAX_COLS   = 32;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ECOL_W     = COL_W + 1;
    localparam int ROW_W      = 16;
    localparam int COEFF_W    = 16;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int LAP_W   = VALUE_BITS + 2;
    localparam int PROD_W  = LAP_W + COEFF_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int DELTA_W = SUM_W - FRAC_BITS;
    localparam int UPD_W   = DELTA_W + 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY = 3'd4;

    localparam logic [ECOL_W-1:0]     COLS_RESET     = ECOL_W'(32);
    localparam logic [ROW_W-1:0]      ROWS_RESET     = 16'd32;
    localparam logic [COEFF_W-1:0]    COEFF_RESET    = 16'd6554;
    localparam logic [VALUE_BITS-1:0] BOUNDARY_RESET = 24'h010000;

    typedef struct packed {
        logic [ECOL_W-1:0]            cols;
        logic [ROW_W-1:0]             rows;
        logic [COEFF_W-1:0]           coeff_x;
        logic [COEFF_W-1:0]           coeff_y;
        logic signed [VALUE_BITS-1:0] boundary;
    } hsfs_cfg_t;

    // One cell to be emitted, with its stencil operands already reduced.
    typedef struct packed {
        logic                         edge_cell;
        logic                         flush;
        logic [ROW_W-1:0]             row;
        logic [COL_W-1:0]             col;
        logic signed [VALUE_BITS-1:0] u;
        logic signed [LAP_W-1:0]      lap_x;
        logic signed [LAP_W-1:0]      lap_y;
    } hsfs_item_t;

    function automatic logic [ECOL_W-1:0] eff_cols(input logic [ECOL_W-1:0] cols);
        logic [ECOL_W-1:0] ec;
        ec = cols;
        if (cols < ECOL_W'(3)) begin
            ec = ECOL_W'(3);
        end else if (cols > ECOL_W'(MAX_COLS)) begin
            ec = ECOL_W'(MAX_COLS);
        end
        return ec;
    endfunction

    function automatic logic [ROW_W-1:0] eff_rows(input logic [ROW_W-1:0] rows);
        logic [ROW_W-1:0] er;
        er = rows;
        if (rows < ROW_W'(3)) begin
            er = ROW_W'(3);
        end
        return er;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] sat_value(
        input logic signed [UPD_W-1:0] v);
        logic signed [UPD_W-1:0] hi;
        logic signed [UPD_W-1:0] lo;
        logic signed [VALUE_BITS-1:0] r;
        hi = UPD_W'({1'b0, {(VALUE_BITS-1){1'b1}}});
        lo = -hi - UPD_W'(1);
        if (v > hi) begin
            r = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else if (v < lo) begin
            r = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            r = v[VALUE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/hsfs_front.sv =====
// Front end: input beats, position counters, line stores, stencil window and classification.
module hsfs_front import hsfs_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hsfs_cfg_t                    cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_cell_value,
    input  logic [Q_CNT_W-1:0]           q_count,
    output logic                         push,
    output hsfs_item_t                   push_item
);

    logic [VALUE_BITS-1:0] store_a [MAX_COLS];
    logic [VALUE_BITS-1:0] store_b [MAX_COLS];

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             bank_reg, bank_next;

    logic signed [VALUE_BITS-1:0] rd_a_reg, rd_b_reg;
    logic signed [VALUE_BITS-1:0] col0_a_reg, col0_b_reg;
    logic signed [VALUE_BITS-1:0] win_l_reg, win_c_reg;

    logic                         f1_valid_reg;
    logic                         f1_bank_reg;
    logic                         f1_emit_reg;
    logic                         f1_edge_reg;
    logic                         f1_flush_reg;
    logic [COL_W-1:0]             f1_col_reg;
    logic [ROW_W-1:0]             f1_row_reg;
    logic signed [VALUE_BITS-1:0] f1_down_reg;

    logic              accept;
    logic [ECOL_W-1:0] ec;
    logic [ROW_W-1:0]  er;
    logic              last_col, last_row, emit, edge_cell, flush;
    logic [COL_W-1:0]  addr_a, addr_b;

    logic signed [VALUE_BITS-1:0] left, center, right, up;
    logic signed [LAP_W-1:0]      lap_x, lap_y;

    assign s_ready = ({1'b0, q_count} + (Q_CNT_W+1)'(f1_valid_reg)) < (Q_CNT_W+1)'(Q_DEPTH);
    assign accept  = s_valid && s_ready;

    always_comb begin
        ec        = eff_cols(cfg.cols);
        er        = eff_rows(cfg.rows);
        last_col  = ({1'b0, col_reg} + ECOL_W'(1)) >= ec;
        last_row  = ({1'b0, row_reg} + (ROW_W+1)'(1)) >= {1'b0, er};
        emit      = (row_reg != '0);
        edge_cell = (row_reg == ROW_W'(1)) || (col_reg == '0) || last_col || (row_reg >= er);
        flush     = last_col && last_row;
        // the bank being filled is read at the cell's column, the other one column ahead
        addr_a    = bank_reg ? (col_reg + COL_W'(1)) : col_reg;
        addr_b    = bank_reg ? col_reg : (col_reg + COL_W'(1));

        col_next  = col_reg;
        row_next  = row_reg;
        bank_next = bank_reg;
        if (accept) begin
            if (flush) begin
                col_next  = '0;
                row_next  = '0;
                bank_next = 1'b0;
            end else if (last_col) begin
                col_next  = '0;
                row_next  = row_reg + ROW_W'(1);
                bank_next = ~bank_reg;
            end else begin
                col_next  = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            bank_reg     <= 1'b0;
            f1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            bank_reg     <= bank_next;
            f1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!bank_reg) begin
                store_a[col_reg] <= s_cell_value;
            end else begin
                store_b[col_reg] <= s_cell_value;
            end
            rd_a_reg <= store_a[addr_a];
            rd_b_reg <= store_b[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (col_reg == '0 && !bank_reg) begin
                col0_a_reg <= s_cell_value;
            end
            if (col_reg == '0 && bank_reg) begin
                col0_b_reg <= s_cell_value;
            end
            f1_bank_reg  <= bank_reg;
            f1_emit_reg  <= emit;
            f1_edge_reg  <= edge_cell;
            f1_flush_reg <= flush;
            f1_col_reg   <= col_reg;
            f1_row_reg   <= row_reg - ROW_W'(1);
            f1_down_reg  <= s_cell_value;
        end
    end

    // window over the row above: left and center slide, right comes from the store
    always_comb begin
        up     = f1_bank_reg ? rd_b_reg : rd_a_reg;
        right  = f1_bank_reg ? rd_a_reg : rd_b_reg;
        center = win_c_reg;
        if (f1_col_reg == '0) begin
            center = f1_bank_reg ? col0_a_reg : col0_b_reg;
        end
        left   = win_l_reg;
        lap_x  = LAP_W'(left) + LAP_W'(right) - (LAP_W'(center) <<< 1);
        lap_y  = LAP_W'(up) + LAP_W'(f1_down_reg) - (LAP_W'(center) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (f1_valid_reg) begin
            win_l_reg <= center;
            win_c_reg <= right;
        end
    end

    assign push = f1_valid_reg && f1_emit_reg;

    always_comb begin
        push_item.edge_cell = f1_edge_reg;
        push_item.flush     = f1_flush_reg;
        push_item.row       = f1_row_reg;
        push_item.col       = f1_col_reg;
        push_item.u         = center;
        push_item.lap_x     = lap_x;
        push_item.lap_y     = lap_y;
    end

endmodule

// ===== src/hsfs_queue.sv =====
// Short queue of classified cells between the front end and the arithmetic back end.
module hsfs_queue import hsfs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  hsfs_item_t         push_item,
    input  logic               pop,
    output hsfs_item_t         head,
    output logic [Q_CNT_W-1:0] count
);

    hsfs_item_t entry_reg [Q_DEPTH];

    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/hsfs_back.sv =====
// Back end: coefficient products, rounding, saturation, last-row flush and the result register.
module hsfs_back import hsfs_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hsfs_cfg_t                    cfg,
    input  hsfs_item_t                   head,
    input  logic [Q_CNT_W-1:0]           q_count,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_new_value,
    output logic [ROW_W-1:0]             m_out_row,
    output logic [COL_W-1:0]             m_out_col,
    output logic                         m_frame_done
);

    logic             flushing_reg, flushing_next;
    logic [COL_W-1:0] fl_col_reg, fl_col_next;
    logic [ROW_W-1:0] fl_row_reg, fl_row_next;

    logic                         p1_valid_reg, p1_edge_reg, p1_done_reg;
    logic [ROW_W-1:0]             p1_row_reg;
    logic [COL_W-1:0]             p1_col_reg;
    logic signed [VALUE_BITS-1:0] p1_u_reg;
    logic signed [PROD_W-1:0]     p1_px_reg, p1_py_reg;

    logic                         p2_valid_reg, p2_edge_reg, p2_done_reg;
    logic [ROW_W-1:0]             p2_row_reg;
    logic [COL_W-1:0]             p2_col_reg;
    logic signed [VALUE_BITS-1:0] p2_u_reg;
    logic signed [DELTA_W-1:0]    p2_delta_reg;

    logic                         out_valid_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    logic [ROW_W-1:0]             out_row_reg;
    logic [COL_W-1:0]             out_col_reg;
    logic                         out_done_reg;

    logic                     advance;
    logic                     take;
    logic [ECOL_W-1:0]        ec;
    logic                     fl_last;
    logic signed [PROD_W-1:0] px, py;
    logic signed [SUM_W-1:0]  sum;
    logic signed [UPD_W-1:0]  upd;

    assign advance = !out_valid_reg || m_ready;
    assign take    = advance && !flushing_reg && (q_count != '0);
    assign pop     = take;

    always_comb begin
        ec            = eff_cols(cfg.cols);
        fl_last       = ({1'b0, fl_col_reg} + ECOL_W'(1)) == ec;
        px            = PROD_W'(head.lap_x) * $signed({1'b0, cfg.coeff_x});
        py            = PROD_W'(head.lap_y) * $signed({1'b0, cfg.coeff_y});
        flushing_next = flushing_reg;
        fl_col_next   = fl_col_reg;
        fl_row_next   = fl_row_reg;
        if (advance && flushing_reg) begin
            fl_col_next = fl_col_reg + COL_W'(1);
            if (fl_last) begin
                flushing_next = 1'b0;
            end
        end else if (take && head.flush) begin
            flushing_next = 1'b1;
            fl_col_next   = '0;
            fl_row_next   = head.row + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flushing_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            flushing_reg <= flushing_next;
            if (advance) begin
                p1_valid_reg  <= flushing_reg || take;
                p2_valid_reg  <= p1_valid_reg;
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fl_col_reg <= fl_col_next;
        fl_row_reg <= fl_row_next;
    end

    // the flushed last row is all boundary
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (flushing_reg) begin
                p1_edge_reg <= 1'b1;
                p1_done_reg <= fl_last;
                p1_row_reg  <= fl_row_reg;
                p1_col_reg  <= fl_col_reg;
            end else begin
                p1_edge_reg <= head.edge_cell;
                p1_done_reg <= 1'b0;
                p1_row_reg  <= head.row;
                p1_col_reg  <= head.col;
            end
            p1_u_reg  <= head.u;
            p1_px_reg <= px;
            p1_py_reg <= py;
        end
    end

    assign sum = SUM_W'(p1_px_reg) + SUM_W'(p1_py_reg) + SUM_W'(32768);

    always_ff @(posedge aclk) begin
        if (advance) begin
            p2_edge_reg  <= p1_edge_reg;
            p2_done_reg  <= p1_done_reg;
            p2_row_reg   <= p1_row_reg;
            p2_col_reg   <= p1_col_reg;
            p2_u_reg     <= p1_u_reg;
            p2_delta_reg <= sum[SUM_W-1:FRAC_BITS];
        end
    end

    assign upd = UPD_W'(p2_u_reg) + UPD_W'(p2_delta_reg);

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_value_reg <= p2_edge_reg ? cfg.boundary : sat_value(upd);
            out_row_reg   <= p2_row_reg;
            out_col_reg   <= p2_col_reg;
            out_done_reg  <= p2_done_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_new_value  = out_value_reg;
    assign m_out_row    = out_row_reg;
    assign m_out_col    = out_col_reg;
    assign m_frame_done = out_done_reg;

endmodule

// ===== src/heat_stencil_ftcs_step_unit.sv =====
// Top level of the FTCS heat stencil step unit: configuration registers and block wiring.
//
// Cells enter in row-major order, one beat per cycle while s_ready is high,
// and each beat of row r (r >= 1) yields the new value of cell (r-1, c);
// rows 0 and the last row are boundary, and the last beat of a frame also
// releases the whole last row, so that beat yields up to MAX_COLS+1 results.
// Sustained rate is one cell per cycle in and one result per cycle out while
// m_ready holds and no last-row flush is under way. An input beat passes the
// line store read register, the queue, then product, rounding and saturation
// stages. A four-entry queue parts the front end from the arithmetic, so
// input is still taken while results wait downstream.
// Configuration writes take effect at once and belong between frames.
module heat_stencil_ftcs_step_unit import hsfs_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_cell_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_new_value,
    output logic [ROW_W-1:0]             m_out_row,
    output logic [COL_W-1:0]             m_out_col,
    output logic                         m_frame_done
);

    hsfs_cfg_t          cfg_reg;
    logic               push, pop;
    hsfs_item_t         push_item, head;
    logic [Q_CNT_W-1:0] q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cols     <= COLS_RESET;
            cfg_reg.rows     <= ROWS_RESET;
            cfg_reg.coeff_x  <= COEFF_RESET;
            cfg_reg.coeff_y  <= COEFF_RESET;
            cfg_reg.boundary <= BOUNDARY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLS:     cfg_reg.cols     <= cfg_wr_data[ECOL_W-1:0];
                REG_ROWS:     cfg_reg.rows     <= cfg_wr_data[ROW_W-1:0];
                REG_COEFF_X:  cfg_reg.coeff_x  <= cfg_wr_data[COEFF_W-1:0];
                REG_COEFF_Y:  cfg_reg.coeff_y  <= cfg_wr_data[COEFF_W-1:0];
                REG_BOUNDARY: cfg_reg.boundary <= cfg_wr_data[VALUE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    hsfs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_value (s_cell_value),
        .q_count      (q_count),
        .push         (push),
        .push_item    (push_item)
    );

    hsfs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .count     (q_count)
    );

    hsfs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .head         (head),
        .q_count      (q_count),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_value  (m_new_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_done (m_frame_done)
    );

endmodule

// ===== src/hsfs_checker.sv =====
// Port-level checks for the FTCS heat stencil step unit, bound to the top level.
module hsfs_checker import hsfs_pkg::*; (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [VALUE_BITS-1:0] m_new_value,
    input logic [ROW_W-1:0]             m_out_row,
    input logic [COL_W-1:0]             m_out_col,
    input logic                         m_frame_done
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    a_done_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> (m_out_row >= ROW_W'(2) && m_out_col >= COL_W'(2)))
        else $error("frame end flagged at an impossible position");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result beat dropped while stalled");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_new_value) && $stable(m_out_row)
                                   && $stable(m_out_col) && $stable(m_frame_done)))
        else $error("result payload changed while stalled");

endmodule

bind heat_stencil_ftcs_step_unit hsfs_checker u_hsfs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_new_value  (m_new_value),
    .m_out_row    (m_out_row),
    .m_out_col    (m_out_col),
    .m_frame_done (m_frame_done)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the FTCS heat stencil step unit: directed and random frames.
module tb;
    import hsfs_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_CELLS  = 120;
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic [ROW_W-1:0]             row;
        logic [COL_W-1:0]             col;
        logic                         done;
    } cell_result_t;

    logic                         aclk         = 1'b0;
    logic                         aresetn      = 1'b0;
    logic                         cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index    = '0;
    logic [CFG_DATA_W-1:0]        cfg_wr_data  = '0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic signed [VALUE_BITS-1:0] s_cell_value = '0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic signed [VALUE_BITS-1:0] m_new_value;
    logic [ROW_W-1:0]             m_out_row;
    logic [COL_W-1:0]             m_out_col;
    logic                         m_frame_done;

    // grid model: register copies, two line stores, position counters
    logic [ECOL_W-1:0]            cfg_cols;
    logic [ROW_W-1:0]             cfg_rows;
    logic [COEFF_W-1:0]           cfg_coeff_x;
    logic [COEFF_W-1:0]           cfg_coeff_y;
    logic signed [VALUE_BITS-1:0] cfg_boundary;
    longint                       line_mem [2][MAX_COLS];
    logic [COL_W-1:0]             col_pos;
    logic [ROW_W-1:0]             row_pos;
    bit                           bank;

    cell_result_t expected_cells[$];
    int           mismatch_count = 0;
    int           idle_pct       = 0;
    int           stall_pct      = 0;

    heat_stencil_ftcs_step_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_value (s_cell_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_value  (m_new_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_done (m_frame_done)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_CYCLES * 8);
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int grid_cols();
        int n;
        n = cfg_cols;
        if (n < 3) n = 3;
        if (n > MAX_COLS) n = MAX_COLS;
        return n;
    endfunction

    function automatic int grid_rows();
        int n;
        n = cfg_rows;
        if (n < 3) n = 3;
        return n;
    endfunction

    // u + cx*lap_x + cy*lap_y, rounded half up once, saturated
    function automatic longint diffuse(input longint u, input longint l, input longint r,
                                       input longint up, input longint dn);
        longint acc;
        longint nv;
        acc = (l + r - 2 * u) * longint'(cfg_coeff_x)
            + (up + dn - 2 * u) * longint'(cfg_coeff_y) + 32768;
        nv = u + (acc >>> 16);
        if (nv > VALUE_MAX) nv = VALUE_MAX;
        if (nv < VALUE_MIN) nv = VALUE_MIN;
        return nv;
    endfunction

    function automatic void expect_cell(input longint v, input int r, input int c,
                                        input bit done);
        cell_result_t res;
        res.value = v[VALUE_BITS-1:0];
        res.row   = r[ROW_W-1:0];
        res.col   = c[COL_W-1:0];
        res.done  = done;
        expected_cells.push_back(res);
    endfunction

    function automatic void advance_grid(input logic signed [VALUE_BITS-1:0] in_value);
        int     ec;
        int     er;
        int     c;
        int     r;
        int     j;
        bit     last_col;
        bit     last_row;
        longint v;
        longint nv;
        ec = grid_cols();
        er = grid_rows();
        c  = col_pos;
        r  = row_pos;
        v  = in_value;
        last_col = (c + 1 >= ec);
        last_row = (r + 1 >= er);
        if (r >= 1) begin
            if (r == 1 || c == 0 || last_col || r >= er) begin
                nv = cfg_boundary;
            end else begin
                nv = diffuse(line_mem[bank ^ 1'b1][c], line_mem[bank ^ 1'b1][c - 1],
                             line_mem[bank ^ 1'b1][c + 1], line_mem[bank][c], v);
            end
            expect_cell(nv, r - 1, c, 1'b0);
        end
        line_mem[bank][c] = v;
        if (last_col && last_row) begin
            for (j = 0; j < ec; j++) begin
                expect_cell(cfg_boundary, r, j, (j + 1 == ec));
            end
            col_pos = '0;
            row_pos = '0;
            bank    = 1'b0;
        end else if (last_col) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
            bank    = bank ^ 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                advance_grid(s_cell_value);
            end
            if (m_valid && m_ready) begin
                if (expected_cells.size() == 0) begin
                    mismatch_count++;
                    $error("unexpected beat: row %0d col %0d", m_out_row, m_out_col);
                end else begin
                    want = expected_cells.pop_front();
                    if (m_new_value !== want.value) begin
                        mismatch_count++;
                        $error("new_value: expected %0d, got %0d", want.value, m_new_value);
                    end
                    if (m_out_row !== want.row) begin
                        mismatch_count++;
                        $error("out_row: expected %0d, got %0d", want.row, m_out_row);
                    end
                    if (m_out_col !== want.col) begin
                        mismatch_count++;
                        $error("out_col: expected %0d, got %0d", want.col, m_out_col);
                    end
                    if (m_frame_done !== want.done) begin
                        mismatch_count++;
                        $error("frame_done: expected %0d, got %0d", want.done, m_frame_done);
                    end
                end
            end
        end
    end

    function automatic logic signed [VALUE_BITS-1:0] pick_cell();
        case ($urandom_range(7))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2, 3: return VALUE_BITS'($urandom_range(61440, 69632));
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coeff();
        case ($urandom_range(5))
            0: return CFG_DATA_W'(0);
            1: return CFG_DATA_W'(32768);
            2: return CFG_DATA_W'(65535);
            default: return CFG_DATA_W'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic set_traffic(input int phase);
        case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COLS:     cfg_cols     = data[ECOL_W-1:0];
            REG_ROWS:     cfg_rows     = data[ROW_W-1:0];
            REG_COEFF_X:  cfg_coeff_x  = data[COEFF_W-1:0];
            REG_COEFF_Y:  cfg_coeff_y  = data[COEFF_W-1:0];
            REG_BOUNDARY: cfg_boundary = data[VALUE_BITS-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_cell(input logic signed [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold off the sender until every pending beat is out
    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic send_cells(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(63) == 0) drain_results(0);
            send_cell(pick_cell());
        end
    endtask

    task automatic send_plus_frame(input logic signed [VALUE_BITS-1:0] outer,
                                   input logic signed [VALUE_BITS-1:0] center);
        int k;
        for (k = 0; k < 9; k++) begin
            send_cell((k == 4) ? center : outer);
        end
    endtask

    task automatic test_default_config();
        set_traffic(0);
        send_cells(2 * grid_cols());
        drain_results(SETTLE_CYCLES);
        write_reg(REG_ROWS, CFG_DATA_W'(3));
        send_cells(grid_cols());
        drain_results(SETTLE_CYCLES);
    endtask

    // 3x3 frames: one interior cell driven to both saturation limits, then zero gain
    task automatic test_field_extremes();
        set_traffic(1);
        write_reg(REG_COLS, CFG_DATA_W'(3));
        write_reg(REG_ROWS, CFG_DATA_W'(3));
        write_reg(REG_COEFF_X, CFG_DATA_W'(32768));
        write_reg(REG_COEFF_Y, CFG_DATA_W'(32768));
        write_reg(REG_BOUNDARY, CFG_DATA_W'(VALUE_MIN));
        send_plus_frame(VALUE_MAX, VALUE_MIN);
        drain_results(SETTLE_CYCLES);
        write_reg(REG_COEFF_X, CFG_DATA_W'(65535));
        write_reg(REG_COEFF_Y, CFG_DATA_W'(65535));
        write_reg(REG_BOUNDARY, CFG_DATA_W'(VALUE_MAX));
        send_plus_frame(VALUE_MIN, VALUE_MAX);
        drain_results(SETTLE_CYCLES);
        write_reg(REG_COEFF_X, CFG_DATA_W'(0));
        write_reg(REG_COEFF_Y, CFG_DATA_W'(0));
        write_reg(REG_BOUNDARY, CFG_DATA_W'(0));
        send_plus_frame('0, '1);
        drain_results(SETTLE_CYCLES);
    endtask

    task automatic test_size_clamp();
        set_traffic(2);
        write_reg(REG_COEFF_X, pick_coeff());
        write_reg(REG_COEFF_Y, pick_coeff());
        write_reg(REG_BOUNDARY, CFG_DATA_W'($urandom));
        write_reg(REG_COLS, CFG_DATA_W'(0));
        write_reg(REG_ROWS, CFG_DATA_W'(0));
        send_cells(grid_cols() * grid_rows());
        drain_results(SETTLE_CYCLES);
        write_reg(REG_COLS, CFG_DATA_W'(63));
        write_reg(REG_ROWS, CFG_DATA_W'(2));
        send_cells(grid_cols() * grid_rows());
        drain_results(SETTLE_CYCLES);
    endtask

    // shrink cols mid-row, then cut rows below the current row
    task automatic test_midframe_change();
        set_traffic(3);
        write_reg(REG_COLS, CFG_DATA_W'(5));
        write_reg(REG_ROWS, CFG_DATA_W'(65535));
        write_reg(REG_COEFF_X, pick_coeff());
        write_reg(REG_COEFF_Y, pick_coeff());
        write_reg(REG_BOUNDARY, CFG_DATA_W'($urandom));
        send_cells(13);
        drain_results(SETTLE_CYCLES);
        write_reg(REG_COLS, CFG_DATA_W'(3));
        write_reg(REG_COEFF_X, pick_coeff());
        send_cells(4);
        drain_results(SETTLE_CYCLES);
        write_reg(REG_ROWS, CFG_DATA_W'(2));
        send_cells(3);
        drain_results(SETTLE_CYCLES);
    endtask

    task automatic test_random_frames();
        int sent;
        int frame;
        int cells;
        sent  = 0;
        frame = 0;
        while (sent < RANDOM_CELLS) begin
            set_traffic(frame % 4);
            drain_results(SETTLE_CYCLES);
            write_reg(REG_COLS, CFG_DATA_W'(($urandom_range(7) == 0) ?
                      $urandom_range(0, 63) : $urandom_range(3, 8)));
            write_reg(REG_ROWS, CFG_DATA_W'(($urandom_range(7) == 0) ?
                      $urandom_range(0, 4) : $urandom_range(3, 7)));
            write_reg(REG_COEFF_X, pick_coeff());
            write_reg(REG_COEFF_Y, pick_coeff());
            write_reg(REG_BOUNDARY, ($urandom_range(3) == 0) ? CFG_DATA_W'(pick_cell()) :
                      CFG_DATA_W'($urandom));
            cells = grid_cols() * grid_rows();
            send_cells(cells);
            sent += cells;
            frame++;
        end
    endtask

    initial begin
        cfg_cols     = COLS_RESET;
        cfg_rows     = ROWS_RESET;
        cfg_coeff_x  = COEFF_RESET;
        cfg_coeff_y  = COEFF_RESET;
        cfg_boundary = BOUNDARY_RESET;
        col_pos      = '0;
        row_pos      = '0;
        bank         = 1'b0;
        foreach (line_mem[i, j]) line_mem[i][j] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_config();
        test_field_extremes();
        test_size_clamp();
        test_midframe_change();
        test_random_frames();
        drain_results(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
